// ----- hw/rtl/rsst_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rsst_pkg
// Shared types and codes for the random sample set table.
// ---------------------------------------------------------------------------
package rsst_pkg;

  localparam int KEY_W   = 32;
  localparam int RAND_W  = 32;
  localparam int COUNT_W = 7;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic [1:0]        command;
    logic [KEY_W-1:0]  key;
    logic [RAND_W-1:0] random_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [KEY_W-1:0]   sampled_key;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rsst_key_store.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rsst_key_store
// Slot memory: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module rsst_key_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rsst_mod_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rsst_mod_unit
// Restoring remainder unit: one dividend bit per cycle.
// ---------------------------------------------------------------------------
module rsst_mod_unit #(
  parameter int CW = 7
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [rsst_pkg::RAND_W-1:0]  dividend,
  input  wire logic [CW-1:0]                divisor,
  output logic                              done,
  output logic      [CW-1:0]                remainder
);

  localparam int SW = $clog2(rsst_pkg::RAND_W);
  localparam logic [SW-1:0] LAST_STEP = SW'(rsst_pkg::RAND_W - 1);

  logic [rsst_pkg::RAND_W-1:0] dvd;
  logic [CW-1:0]               dvs;
  logic [SW-1:0]               step;
  logic                        busy;
  logic [CW:0]                 trial;
  logic [CW:0]                 diff;

  assign trial = {remainder, dvd[rsst_pkg::RAND_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
      step      <= '0;
    end else if (busy) begin
      dvd       <= dvd << 1;
      remainder <= (trial >= {1'b0, dvs}) ? diff[CW-1:0] : trial[CW-1:0];
      step      <= step + SW'(1);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/random_sample_set_table.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// random_sample_set_table
// Set of distinct keys packed in slots 0..count-1 with insert, delete and
// sample by an external random value taken modulo count.
// ---------------------------------------------------------------------------
// One command is taken at a time; req_ready is low until its response is
// loaded. Insert and delete walk the slot memory one slot per cycle through
// its single read port; a delete that moves the last key into the freed slot
// then reads it through S_RD and S_RDW. Sample runs the 32-step remainder
// unit and reads one slot. Empty sample and unused codes go straight to
// S_FIN. Slot contents need no clearing after reset, so a command can be
// taken as soon as reset is released. The response sits in an output
// register, so a waiting response does not hold back the next command.
module random_sample_set_table #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire rsst_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output rsst_pkg::rsp_t      rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int KB = (KEY_BITS < rsst_pkg::KEY_W) ? KEY_BITS : rsst_pkg::KEY_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_RDW  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                  state;
  logic [1:0]                  cmd;
  logic [KB-1:0]               key_m;
  logic [CW-1:0]               count;
  logic [CW-1:0]               idx;
  logic                        cmp_valid;
  logic [CW-1:0]               cmp_idx;
  logic [AW-1:0]               pos;
  logic [AW-1:0]               tgt;
  logic [2:0]                  status;
  logic [rsst_pkg::KEY_W-1:0]  sampled;

  logic                        accept;
  logic                        scan_hit;
  logic                        scan_miss;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [KB-1:0]               wr_data;
  logic [AW-1:0]               rd_addr;
  logic [KB-1:0]               rd_data;
  logic                        mod_start;
  logic                        mod_done;
  logic [CW-1:0]               mod_rem;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign scan_hit  = cmp_valid && (rd_data == key_m);
  assign scan_miss = !cmp_valid && (idx == count);
  assign mod_start = accept && req.command == rsst_pkg::CMD_SAMPLE && count != '0;
  assign rd_addr   = (state == S_RD) ? tgt : idx[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_data = rd_data;
    if (state == S_SCAN && scan_miss && cmd == rsst_pkg::CMD_INSERT &&
        count != FULL_COUNT) begin
      wr_en   = 1'b1;
      wr_addr = count[AW-1:0];
      wr_data = key_m;
    end else if (state == S_RDW && cmd == rsst_pkg::CMD_DELETE) begin
      wr_en = 1'b1;
    end
  end

  rsst_key_store #(
    .DEPTH (CAPACITY),
    .WIDTH (KB)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rsst_mod_unit #(
    .CW (CW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (req.random_value),
    .divisor   (count),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd       <= req.command;
            key_m     <= req.key[KB-1:0];
            idx       <= '0;
            cmp_valid <= 1'b0;
            status    <= (req.command == rsst_pkg::CMD_SAMPLE && count == '0) ?
                         rsst_pkg::ST_EMPTY : rsst_pkg::ST_OK;
            sampled   <= '0;
            priority if (req.command == rsst_pkg::CMD_INSERT ||
                         req.command == rsst_pkg::CMD_DELETE) begin
              state <= S_SCAN;
            end else if (req.command == rsst_pkg::CMD_SAMPLE) begin
              if (count == '0) begin
                state <= S_FIN;
              end else begin
                state <= S_DIV;
              end
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          priority if (scan_hit) begin
            pos <= cmp_idx[AW-1:0];
            if (cmd == rsst_pkg::CMD_INSERT) begin
              status <= rsst_pkg::ST_PRESENT;
              state  <= S_FIN;
            end else if (cmp_idx == count - CW'(1)) begin
              count <= count - CW'(1);
              state <= S_FIN;
            end else begin
              tgt   <= AW'(count - CW'(1));
              state <= S_RD;
            end
          end else if (idx != count) begin
            cmp_valid <= 1'b1;
            cmp_idx   <= idx;
            idx       <= idx + CW'(1);
          end else if (cmp_valid) begin
            cmp_valid <= 1'b0;
          end else begin
            if (cmd == rsst_pkg::CMD_INSERT) begin
              if (count == FULL_COUNT) begin
                status <= rsst_pkg::ST_FULL;
              end else begin
                count <= count + CW'(1);
              end
            end else begin
              status <= rsst_pkg::ST_ABSENT;
            end
            state <= S_FIN;
          end
        end
        S_DIV: begin
          if (mod_done) begin
            tgt   <= mod_rem[AW-1:0];
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          if (cmd == rsst_pkg::CMD_SAMPLE) begin
            sampled <= rsst_pkg::KEY_W'(rd_data);
          end else begin
            count <= count - CW'(1);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!rsp_valid || rsp_ready)) begin
      rsp.status      <= status;
      rsp.sampled_key <= sampled;
      rsp.entry_count <= rsst_pkg::COUNT_W'(count);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rsst_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rsst_checker
// Port-level checks for the random sample set table.
// ---------------------------------------------------------------------------
module rsst_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire rsst_pkg::req_t req,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire rsst_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed before transfer");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready stayed high after a command transfer");

  a_sample_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.sampled_key != '0 |-> rsp.status == rsst_pkg::ST_OK)
    else $error("nonzero sampled key with error status");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == rsst_pkg::ST_EMPTY |-> rsp.entry_count == '0)
    else $error("empty status with nonzero count");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("not idle after reset");

endmodule

bind random_sample_set_table rsst_checker u_rsst_checker (.*);
`default_nettype wire
